@@ rtl/arpt_pkg.sv @@
// Shared constants for the address resolution pending table.
package arpt_pkg;

  localparam int unsigned CAPACITY_DEFAULT    = 16;
  localparam int unsigned HANDLE_BITS_DEFAULT = 10;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned LIMIT_W = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd10;

  localparam logic KIND_PARK    = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  localparam logic RES_RELEASE = 1'b0;
  localparam logic RES_DROP    = 1'b1;

endpackage

@@ rtl/address_resolution_pending_table.sv @@
// Pending frame table: parks frame handles under a next-hop address until it resolves.
//
// Input stream s_axis: tuser = kind (0 park, 1 resolve); tdata = ip_addr, frame_handle, mac_addr.
// Output stream m_axis: tuser = result_kind (0 release, 1 drop); tdata = out_frame, dest_mac;
// tlast marks the final result of one input transfer.
// Config cfg: 4-bit occupancy limit, reset value 10; user writes it only while idle, unchecked.
//
// Entries live in a CAPACITY-deep memory used as a ring, newest entry at the head pointer.
// One address comparator walks the entries under a small sequencer; the walk is bound by
// the single memory read port, one entry per cycle while the output is not stalled.
// - park, no eviction: no result.
// - park with eviction: one drop result.
// - resolve: one release per match, newest first; the table is
//   compacted in the same walk. A resolve on an empty table gives no result.
// s_axis_tready is high only between items. A stalled receiver holds the result in the
// output register and stops the walk at the next match until the register drains.
// After reset the table is empty and the limit is 10; no clearing pass is needed.
module address_resolution_pending_table #(
  parameter int unsigned CAPACITY    = arpt_pkg::CAPACITY_DEFAULT,
  parameter int unsigned HANDLE_BITS = arpt_pkg::HANDLE_BITS_DEFAULT,
  localparam int unsigned IN_W  = arpt_pkg::ADDR_W + HANDLE_BITS + arpt_pkg::MAC_W,
  localparam int unsigned IN_BW = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = HANDLE_BITS + arpt_pkg::MAC_W,
  localparam int unsigned OUT_BW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_BW-1:0]               s_axis_tdata,  // ip_addr, frame_handle, mac_addr
  input  logic                           s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_BW-1:0]              m_axis_tdata,  // out_frame, dest_mac
  output logic                           m_axis_tuser,  // result_kind
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arpt_pkg::LIMIT_W-1:0]   cfg_data
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > arpt_pkg::LIMIT_W) ? CNT_W : arpt_pkg::LIMIT_W;
  localparam int unsigned AW    = arpt_pkg::ADDR_W;
  localparam int unsigned MW    = arpt_pkg::MAC_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVICT = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  typedef struct packed {
    logic [AW-1:0]          addr;
    logic [HANDLE_BITS-1:0] frame;
  } entry_t;

  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    ptr_inc = (p == IDX_W'(CAPACITY - 1)) ? '0 : IDX_W'(p + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    ptr_dec = (p == '0) ? IDX_W'(CAPACITY - 1) : IDX_W'(p - 1'b1);
  endfunction

  logic [1:0]                  state_q, state_d;
  logic [IDX_W-1:0]            head_q, head_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [arpt_pkg::LIMIT_W-1:0] limit_q;
  logic [CNT_W-1:0]            idx_q, idx_d;
  logic [CNT_W-1:0]            kept_q, kept_d;
  logic [IDX_W-1:0]            rd_ptr_q, rd_ptr_d;
  logic [IDX_W-1:0]            wr_ptr_q, wr_ptr_d;
  logic                        pend_valid_q, pend_valid_d;
  logic [HANDLE_BITS-1:0]      pend_frame_q, pend_frame_d;
  logic                        out_valid_q, out_valid_d;

  logic [AW-1:0]               item_addr_q, item_addr_d;
  logic [HANDLE_BITS-1:0]      item_frame_q, item_frame_d;
  logic [MW-1:0]               item_mac_q, item_mac_d;

  logic                        out_kind_q, out_kind_d;
  logic [HANDLE_BITS-1:0]      out_frame_q, out_frame_d;
  logic [MW-1:0]               out_mac_q, out_mac_d;
  logic                        out_last_q, out_last_d;

  entry_t                      mem_q [CAPACITY];
  entry_t                      rd_data_q;
  logic [IDX_W-1:0]            rd_addr;
  logic                        mem_we;
  logic [IDX_W-1:0]            mem_wa;
  entry_t                      mem_wd;

  logic                        s_accept;
  logic                        out_load;
  logic                        out_free;
  logic                        evict;
  logic                        match;
  logic                        advance;

  logic [AW-1:0]               in_addr;
  logic [HANDLE_BITS-1:0]      in_frame;
  logic [MW-1:0]               in_mac;

  assign in_addr  = s_axis_tdata[AW-1:0];
  assign in_frame = s_axis_tdata[AW +: HANDLE_BITS];
  assign in_mac   = s_axis_tdata[AW + HANDLE_BITS +: MW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign evict = (count_q != '0) &&
                 ((CMP_W'(count_q) > CMP_W'(limit_q)) ||
                  (count_q >= CNT_W'(CAPACITY)));
  assign match = (rd_data_q.addr == item_addr_q);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    kept_d       = kept_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    pend_valid_d = pend_valid_q;
    pend_frame_d = pend_frame_q;
    item_addr_d  = item_addr_q;
    item_frame_d = item_frame_q;
    item_mac_d   = item_mac_q;
    out_load     = 1'b0;
    out_kind_d   = out_kind_q;
    out_frame_d  = out_frame_q;
    out_mac_d    = out_mac_q;
    out_last_d   = out_last_q;
    rd_addr      = rd_ptr_q;
    mem_we       = 1'b0;
    mem_wa       = head_q;
    mem_wd       = '{addr: item_addr_q, frame: item_frame_q};
    advance      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        rd_addr = head_q;
        if (s_axis_tvalid) begin
          item_addr_d  = in_addr;
          item_frame_d = in_frame;
          item_mac_d   = in_mac;
          if (s_axis_tuser == arpt_pkg::KIND_PARK) begin
            if (evict) begin
              state_d = S_EVICT;
            end else begin
              mem_we  = 1'b1;
              mem_wa  = ptr_dec(head_q);
              mem_wd  = '{addr: in_addr, frame: in_frame};
              head_d  = ptr_dec(head_q);
              count_d = CNT_W'(count_q + 1'b1);
            end
          end else if (count_q != '0) begin
            state_d  = S_SCAN;
            idx_d    = '0;
            kept_d   = '0;
            rd_ptr_d = head_q;
            wr_ptr_d = head_q;
          end
        end
      end
      S_EVICT: begin
        rd_addr = head_q;
        if (out_free) begin
          out_load    = 1'b1;
          out_kind_d  = arpt_pkg::RES_DROP;
          out_frame_d = rd_data_q.frame;
          out_mac_d   = '0;
          out_last_d  = 1'b1;
          mem_we      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_SCAN: begin
        advance = !match || !pend_valid_q || out_free;
        if (!match) begin
          mem_we   = 1'b1;
          mem_wa   = wr_ptr_q;
          mem_wd   = rd_data_q;
          wr_ptr_d = ptr_inc(wr_ptr_q);
          kept_d   = CNT_W'(kept_q + 1'b1);
        end else if (!pend_valid_q) begin
          pend_valid_d = 1'b1;
          pend_frame_d = rd_data_q.frame;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = arpt_pkg::RES_RELEASE;
          out_frame_d  = pend_frame_q;
          out_mac_d    = item_mac_q;
          out_last_d   = 1'b0;
          pend_frame_d = rd_data_q.frame;
        end
        if (advance) begin
          rd_addr  = ptr_inc(rd_ptr_q);
          rd_ptr_d = ptr_inc(rd_ptr_q);
          idx_d    = CNT_W'(idx_q + 1'b1);
          if (CNT_W'(idx_q + 1'b1) == count_q) begin
            count_d = kept_d;
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = arpt_pkg::RES_RELEASE;
          out_frame_d  = pend_frame_q;
          out_mac_d    = item_mac_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      limit_q      <= arpt_pkg::LIMIT_RESET;
      idx_q        <= '0;
      kept_q       <= '0;
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      kept_q       <= kept_d;
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid && cfg_ready) begin
        limit_q <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_frame_q <= pend_frame_d;
    item_addr_q  <= item_addr_d;
    item_frame_q <= item_frame_d;
    item_mac_q   <= item_mac_d;
    out_kind_q   <= out_kind_d;
    out_frame_q  <= out_frame_d;
    out_mac_q    <= out_mac_d;
    out_last_q   <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_BW'({out_mac_q, out_frame_q});

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_park_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser == arpt_pkg::KIND_PARK && !evict)
    |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("park without eviction did not add an entry");

  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == arpt_pkg::RES_DROP) |-> m_axis_tlast)
    else $error("drop result not marked last");

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("pending release left over between items");

endmodule

@@ tb/address_resolution_pending_table_checker.sv @@
// Checker for the pending table: tracks parked frames, predicts releases and drops, compares.
module address_resolution_pending_table_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [95:0]                   s_tdata_i,
  input  logic                          s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [63:0]                   m_tdata_i,
  input  logic                          m_tuser_i,
  input  logic                          m_tlast_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [arpt_pkg::LIMIT_W-1:0]  cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   outstanding_o,
  output int unsigned                   results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = arpt_pkg::CAPACITY_DEFAULT;
  localparam int unsigned HW    = arpt_pkg::HANDLE_BITS_DEFAULT;
  localparam int unsigned AW    = arpt_pkg::ADDR_W;
  localparam int unsigned MW    = arpt_pkg::MAC_W;
  localparam int unsigned LW    = arpt_pkg::LIMIT_W;

  typedef struct packed {
    logic          kind;
    logic [HW-1:0] frame;
    logic [MW-1:0] mac;
    logic          last;
  } frame_result_t;

  // slot 0 holds the newest parked frame
  logic [AW-1:0]      slot_addr  [SLOTS];
  logic [HW-1:0]      slot_frame [SLOTS];
  int unsigned        stored = 0;
  logic [LW-1:0]      limit_q = arpt_pkg::LIMIT_RESET;
  frame_result_t      expected_results [$];
  int unsigned        fail_count = 0;
  int unsigned        results_seen = 0;

  task automatic park_frame(input logic [AW-1:0] ip, input logic [HW-1:0] handle);
    frame_result_t drop;
    if (stored > 0 && (stored > limit_q || stored >= SLOTS)) begin
      drop = {arpt_pkg::RES_DROP, slot_frame[0], {MW{1'b0}}, 1'b1};
      expected_results.push_back(drop);
      for (int unsigned i = 0; i + 1 < stored; i++) begin
        slot_addr[i]  = slot_addr[i+1];
        slot_frame[i] = slot_frame[i+1];
      end
      stored--;
    end
    for (int unsigned i = stored; i > 0; i--) begin
      slot_addr[i]  = slot_addr[i-1];
      slot_frame[i] = slot_frame[i-1];
    end
    slot_addr[0]  = ip;
    slot_frame[0] = handle;
    stored++;
  endtask

  task automatic resolve_address(input logic [AW-1:0] ip, input logic [MW-1:0] mac);
    frame_result_t hits [$];
    int unsigned   kept;
    kept = 0;
    for (int unsigned i = 0; i < stored; i++) begin
      if (slot_addr[i] == ip) begin
        hits.push_back({arpt_pkg::RES_RELEASE, slot_frame[i], mac, 1'b0});
      end else begin
        slot_addr[kept]  = slot_addr[i];
        slot_frame[kept] = slot_frame[i];
        kept++;
      end
    end
    stored = kept;
    if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
    foreach (hits[k]) expected_results.push_back(hits[k]);
  endtask

  task automatic compare_result(input frame_result_t got);
    frame_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: kind=%0d frame=%h mac=%h last=%0d",
                 got.kind, got.frame, got.mac, got.last);
    end else begin
      want = expected_results.pop_front();
      if (want.kind != got.kind || want.frame != got.frame ||
          want.mac != got.mac || want.last != got.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected kind=%0d frame=%h mac=%h last=%0d",
                   want.kind, want.frame, want.mac, want.last);
          $display("          got      kind=%0d frame=%h mac=%h last=%0d",
                   got.kind, got.frame, got.mac, got.last);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored  = 0;
      limit_q = arpt_pkg::LIMIT_RESET;
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == arpt_pkg::KIND_PARK) park_frame(s_tdata_i[31:0], s_tdata_i[41:32]);
        else resolve_address(s_tdata_i[31:0], s_tdata_i[89:42]);
      end
      if (m_tvalid_i && m_tready_i)
        compare_result({m_tuser_i, m_tdata_i[9:0], m_tdata_i[57:10], m_tlast_i});
    end
    outstanding_o  = expected_results.size();
    fail_count_o   = fail_count;
    results_seen_o = results_seen;
  end

endmodule

@@ tb/address_resolution_pending_table_test.sv @@
// Testbench top for the pending table: clock, reset, stimulus, stalls and verdict.
module address_resolution_pending_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 24;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [95:0]        s_axis_tdata = '0;  // ip_addr, frame_handle, mac_addr
  logic               s_axis_tuser = 1'b0;  // kind
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [63:0]        m_axis_tdata;  // out_frame, dest_mac
  logic               m_axis_tuser;  // result_kind
  logic               m_axis_tlast;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [arpt_pkg::LIMIT_W-1:0] cfg_data = '0;

  int unsigned fail_count, outstanding, results_seen;
  int unsigned cycles = 0;
  int unsigned parks = 0;
  int unsigned resolves = 0;
  int unsigned limits_set = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;
  logic [31:0] addr_pool [4];

  always #10 clk_i = ~clk_i;

  address_resolution_pending_table i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  address_resolution_pending_table_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tuser_i      (m_axis_tuser),
    .m_tlast_i      (m_axis_tlast),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .results_seen_o (results_seen)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic kind, input logic [31:0] ip,
                           input logic [9:0] handle, input logic [47:0] mac);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'd0, mac, handle, ip};
    do @(posedge clk_i); while (!s_axis_tready);
    if (kind == arpt_pkg::KIND_PARK) parks++;
    else resolves++;
  endtask

  task automatic park(input logic [31:0] ip, input logic [9:0] handle);
    send_item(arpt_pkg::KIND_PARK, ip, handle, 48'({$urandom, $urandom}));
  endtask

  task automatic resolve(input logic [31:0] ip, input logic [47:0] mac);
    send_item(arpt_pkg::KIND_RESOLVE, ip, 10'($urandom_range(0, 1023)), mac);
  endtask

  // lets results drain and the walk finish so the block is idle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_limit(input logic [arpt_pkg::LIMIT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limits_set++;
  endtask

  task automatic refresh_pool();
    foreach (addr_pool[i]) addr_pool[i] = $urandom;
  endtask

  task automatic random_traffic(input int unsigned count, input int unsigned park_pct);
    logic [31:0] ip;
    for (int unsigned n = 0; n < count; n++) begin
      ip = ($urandom_range(0, 7) == 0) ? $urandom : addr_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 99) < park_pct) park(ip, 10'($urandom_range(0, 1023)));
      else resolve(ip, 48'({$urandom, $urandom}));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit of 10: empty resolve, field extremes, eviction, no-match resolve
    resolve(32'h0000_0000, 48'h0);
    park(32'h0000_0000, 10'h000);
    park(32'hFFFF_FFFF, 10'h3FF);
    park(32'h0000_0000, 10'h155);
    park(32'hFFFF_FFFF, 10'h2AA);
    park(32'hC0A8_0001, 10'h001);
    resolve(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 10; i++) park(32'h0A00_0001 + 32'(i), 10'h100 + 10'(i));
    resolve(32'h0000_0000, 48'h0123_4567_89AB);
    resolve(32'h1234_5678, 48'hAAAA_5555_AAAA);
    resolve(32'h0A00_0001, 48'h0);

    // limit of zero: every park into a non-empty table evicts
    set_limit(4'd0);
    for (int i = 0; i < 4; i++) park(32'h7F00_0001, 10'($urandom_range(0, 1023)));
    resolve(32'h7F00_0001, 48'h5555_AAAA_5555);
    resolve(32'hC0A8_0001, 48'({$urandom, $urandom}));

    // largest limit: fill the table until it is full
    set_limit(4'd15);
    refresh_pool();
    random_traffic(18, 100);
    random_traffic(20, 60);

    set_limit(4'd1);
    refresh_pool();
    random_traffic(25, 60);

    set_limit(4'($urandom_range(2, 14)));
    refresh_pool();
    calm = 1'b1;
    random_traffic(25, 65);

    wait_idle();
    $display("Sent %0d parks and %0d resolves under %0d limit settings (reset, 0, 15, 1, mid).",
             parks, resolves, limits_set + 1);
    $display("Compared %0d results, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/arpt_pkg.sv
rtl/address_resolution_pending_table.sv
tb/address_resolution_pending_table_checker.sv
tb/address_resolution_pending_table_test.sv
